@@ design/poi_pkg.sv @@
// Package for the planar odometry integrator: request codes, FSM state type,
// CORDIC constants and the arctangent table. No dependencies.
`timescale 1ns / 1ps
package poi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

  typedef enum logic [1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_PREDICT = 2'd1,
    REQ_SET     = 2'd2,
    REQ_FORCE   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/poi_cordic.sv @@
// Iterative CORDIC: one rotation per cycle, sine and cosine in Q3.28.
// Depends on poi_pkg for the step count, gain and arctangent table.
`timescale 1ns / 1ps
module poi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  logic signed [31:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [1:0]         quad_r;
  logic [4:0]         step_r;
  logic               busy_r;
  logic signed [31:0] sx, sy;
  logic signed [32:0] atan_v;

  assign sx     = x_r >>> step_r;
  assign sy     = y_r >>> step_r;
  assign atan_v = $signed({3'b000, poi_pkg::atan_entry(step_r)});
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 5'd1;
      if (step_r == 5'(poi_pkg::CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= poi_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({3'b000, angle[29:0]});
      quad_r <= angle[31:30];
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + atan_v;
      end
    end
  end

  // apply the quadrant exactly
  always_comb begin
    case (quad_r)
      2'd0: begin cos_q = x_r;  sin_q = y_r;  end
      2'd1: begin cos_q = -y_r; sin_q = x_r;  end
      2'd2: begin cos_q = -x_r; sin_q = -y_r; end
      default: begin cos_q = y_r; sin_q = -x_r; end
    endcase
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= 5'(poi_pkg::CORDIC_STEPS - 1)))
    else $error("cordic step counter overran");
  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && step_r == 5'd0 && x_r == poi_pkg::CORDIC_GAIN))
    else $error("cordic did not initialize on start");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && step_r == 5'(poi_pkg::CORDIC_STEPS - 1)) |=> !busy_r)
    else $error("cordic did not stop after last step");

endmodule

@@ design/planar_odometry_integrator_core.sv @@
// Set pose, force orientation, invalid time and zero-dt predict give the result
// in the cycle after the transaction; update and other predicts run bit-serial
// dt products (ST_MUL1, with CORDIC alongside), bit-serial rotation products
// (ST_MUL2) and a finish step (ST_FIN). One transaction at a time; input taken
// again once the result register frees. Synchronous reset zeroes pose, held
// velocities, time stamp and initialized flag. Uses poi_pkg and poi_cordic.
`timescale 1ns / 1ps
module planar_odometry_integrator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [31:0]        in_time_stamp,
  input  logic signed [23:0] in_vel_x_in,
  input  logic signed [23:0] in_vel_y_in,
  input  logic signed [23:0] in_yaw_rate_in,
  input  logic signed [31:0] in_pose_x_in,
  input  logic signed [31:0] in_pose_y_in,
  input  logic [31:0]        in_heading_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic [31:0]        out_heading_out,
  output logic               out_is_initialized
);

  poi_pkg::state_t state_r;

  logic signed [31:0] pos_x_r, pos_y_r;
  logic [31:0]        heading_r, last_time_r;
  logic signed [23:0] vel_x_r, vel_y_r, yaw_r;
  logic               init_r;

  logic [1:0]         req_r;
  logic [31:0]        t_r;
  logic signed [23:0] nvx_r, nvy_r, nyaw_r;

  logic               out_valid_r, status_r, oinit_r;
  logic signed [31:0] ox_r, oy_r;
  logic [31:0]        oh_r;

  logic [4:0]         cnt_r;
  logic [31:0]        dt_sh_r;
  logic signed [56:0] addx_r, addy_r, accx_r, accy_r;
  logic signed [56:0] accx_nxt, accy_nxt;
  logic [31:0]        addw_r, accw_r, accw_nxt;
  logic [31:0]        s_sh_r, c_sh_r;
  logic signed [67:0] bxa_r, bya_r, gx_r, gy_r, gx_nxt, gy_nxt;
  logic signed [34:0] bx_nxt, by_nxt;
  logic signed [39:0] fx_nxt, fy_nxt;

  logic               out_free, acc_in, cordic_start, cordic_busy, last_step;
  logic               t_early, out_set;
  logic signed [31:0] sin_q, cos_q;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == poi_pkg::ST_IDLE && out_free);
  assign acc_in    = in_valid && !in_stall;
  assign t_early   = in_time_stamp < last_time_r;
  assign last_step = (cnt_r == 5'd31);
  assign cordic_start = acc_in && !t_early &&
      (in_req_type == poi_pkg::REQ_UPDATE ||
       (in_req_type == poi_pkg::REQ_PREDICT && in_time_stamp != last_time_r));
  // raise the result at once unless the transaction needs the long path
  assign out_set = (acc_in && !cordic_start) ||
      (state_r == poi_pkg::ST_FIN && out_free);

  poi_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (heading_r),
    .busy  (cordic_busy),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  function automatic logic signed [34:0] clamp_disp(input logic signed [56:0] p);
    logic signed [40:0] q;
    q = 41'(p >>> 16);
    if (q > 41'sh2_0000_0000) return 35'sh2_0000_0000;
    if (q < -41'sh2_0000_0000) return -35'sh2_0000_0000;
    return q[34:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fff_ffff;
    if (v < -40'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [67:0] term(input logic b, input logic neg,
                                              input logic signed [67:0] a);
    if (!b) return '0;
    return neg ? -a : a;
  endfunction

  always_comb begin
    accx_nxt = accx_r + (dt_sh_r[0] ? addx_r : 57'sd0);
    accy_nxt = accy_r + (dt_sh_r[0] ? addy_r : 57'sd0);
    accw_nxt = accw_r + (dt_sh_r[0] ? addw_r : 32'd0);
    bx_nxt   = clamp_disp(accx_nxt);
    by_nxt   = clamp_disp(accy_nxt);
    // sign bit of sine and cosine carries negative weight
    gx_nxt = gx_r + term(s_sh_r[0], last_step, bxa_r) - term(c_sh_r[0], last_step, bya_r);
    gy_nxt = gy_r + term(c_sh_r[0], last_step, bxa_r) + term(s_sh_r[0], last_step, bya_r);
    fx_nxt = gx_r[67:28] + 40'(pos_x_r);
    fy_nxt = gy_r[67:28] + 40'(pos_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_set) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= poi_pkg::ST_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      yaw_r       <= '0;
      last_time_r <= '0;
      init_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      case (state_r)
        poi_pkg::ST_IDLE: begin
          if (acc_in) begin
            req_r    <= in_req_type;
            t_r      <= in_time_stamp;
            nvx_r    <= in_vel_x_in;
            nvy_r    <= in_vel_y_in;
            nyaw_r   <= in_yaw_rate_in;
            status_r <= t_early && (in_req_type == poi_pkg::REQ_UPDATE ||
                                    in_req_type == poi_pkg::REQ_PREDICT);
            case (in_req_type)
              poi_pkg::REQ_SET: begin
                pos_x_r     <= in_pose_x_in;
                pos_y_r     <= in_pose_y_in;
                heading_r   <= in_heading_in;
                last_time_r <= in_time_stamp;
                init_r      <= 1'b1;
                ox_r        <= in_pose_x_in;
                oy_r        <= in_pose_y_in;
                oh_r        <= in_heading_in;
                oinit_r     <= 1'b1;
              end
              poi_pkg::REQ_FORCE: begin
                heading_r <= in_heading_in;
                yaw_r     <= '0;
                ox_r      <= pos_x_r;
                oy_r      <= pos_y_r;
                oh_r      <= in_heading_in;
                oinit_r   <= init_r;
              end
              default: begin
                oinit_r <= init_r;
                if (t_early && in_req_type == poi_pkg::REQ_PREDICT) begin
                  ox_r <= '0;
                  oy_r <= '0;
                  oh_r <= '0;
                end else begin
                  ox_r <= pos_x_r;
                  oy_r <= pos_y_r;
                  oh_r <= heading_r;
                end
                if (cordic_start) begin
                  dt_sh_r <= in_time_stamp - last_time_r;
                  addx_r  <= 57'(vel_x_r);
                  addy_r  <= 57'(vel_y_r);
                  addw_r  <= 32'(yaw_r);
                  accx_r  <= '0;
                  accy_r  <= '0;
                  accw_r  <= '0;
                  cnt_r   <= '0;
                  state_r <= poi_pkg::ST_MUL1;
                end
              end
            endcase
          end
        end
        poi_pkg::ST_MUL1: begin
          accx_r  <= accx_nxt;
          accy_r  <= accy_nxt;
          accw_r  <= accw_nxt;
          addx_r  <= addx_r <<< 1;
          addy_r  <= addy_r <<< 1;
          addw_r  <= addw_r << 1;
          dt_sh_r <= dt_sh_r >> 1;
          cnt_r   <= cnt_r + 5'd1;
          if (last_step) begin
            bxa_r   <= 68'(bx_nxt);
            bya_r   <= 68'(by_nxt);
            s_sh_r  <= sin_q;
            c_sh_r  <= cos_q;
            gx_r    <= '0;
            gy_r    <= '0;
            state_r <= poi_pkg::ST_MUL2;
          end
        end
        poi_pkg::ST_MUL2: begin
          gx_r   <= gx_nxt;
          gy_r   <= gy_nxt;
          bxa_r  <= bxa_r <<< 1;
          bya_r  <= bya_r <<< 1;
          s_sh_r <= s_sh_r >> 1;
          c_sh_r <= c_sh_r >> 1;
          cnt_r  <= cnt_r + 5'd1;
          if (last_step) state_r <= poi_pkg::ST_FIN;
        end
        poi_pkg::ST_FIN: begin
          if (out_free) begin
            ox_r        <= clamp32(fx_nxt);
            oy_r        <= clamp32(fy_nxt);
            oh_r        <= heading_r + accw_r;
            state_r     <= poi_pkg::ST_IDLE;
            if (req_r == poi_pkg::REQ_UPDATE) begin
              pos_x_r     <= clamp32(fx_nxt);
              pos_y_r     <= clamp32(fy_nxt);
              heading_r   <= heading_r + accw_r;
              vel_x_r     <= nvx_r;
              vel_y_r     <= nvy_r;
              yaw_r       <= nyaw_r;
              last_time_r <= t_r;
            end
          end
        end
        default: state_r <= poi_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_pos_x_out      = ox_r;
  assign out_pos_y_out      = oy_r;
  assign out_heading_out    = oh_r;
  assign out_is_initialized = oinit_r;

  a_cordic_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == poi_pkg::ST_MUL1 && last_step) |-> !cordic_busy)
    else $error("cordic still busy when rotation products start");
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != poi_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while a transaction is in progress");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == poi_pkg::ST_IDLE || state_r == poi_pkg::ST_FIN))
    else $error("result raised outside idle or finish");

endmodule

@@ verif/planar_odometry_integrator_core_tb.sv @@
// Testbench for planar_odometry_integrator_core: drives random and directed
// odometry requests, predicts each result in SystemVerilog, compares outputs.
// Depends on poi_pkg and the core RTL.
`timescale 1ns / 1ps
module planar_odometry_integrator_core_tb;

  typedef struct packed {
    poi_pkg::req_t      req;
    logic [31:0]        stamp;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] yaw;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hd;
  } odo_req_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        hd;
    logic               init;
  } pose_rsp_t;

  localparam longint DISP_MAX = 64'sd1 << 33;
  localparam int MAX_CYCLES = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [31:0] in_time_stamp = '0;
  logic signed [23:0] in_vel_x_in = '0, in_vel_y_in = '0, in_yaw_rate_in = '0;
  logic signed [31:0] in_pose_x_in = '0, in_pose_y_in = '0;
  logic [31:0] in_heading_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic signed [31:0] out_pos_x_out, out_pos_y_out;
  logic [31:0] out_heading_out;
  logic out_is_initialized;

  planar_odometry_integrator_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted block state
  logic signed [31:0] st_x, st_y, st_vx, st_vy, st_yaw;
  logic [31:0] st_hd, st_time;
  logic st_init;

  odo_req_t pending_reqs[$];
  pose_rsp_t expected_poses[$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 0;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint s, output longint c);
    longint x, y, z, sx, sy, ta;
    x = 163008219;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < poi_pkg::CORDIC_STEPS; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      ta = longint'(poi_pkg::atan_entry(i[4:0]));
      if (z >= 0) begin
        x = x - sy; y = y + sx; z = z - ta;
      end else begin
        x = x + sy; y = y - sx; z = z + ta;
      end
    end
    case (ang[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic void dead_reckon(input logic [31:0] dt, output logic signed [31:0] nx,
                                      output logic signed [31:0] ny, output logic [31:0] nh);
    longint bx, by, s, c, gx, gy, d;
    d = longint'({32'd0, dt});
    bx = sat((longint'(st_vx) * d) >>> 16, -DISP_MAX, DISP_MAX);
    by = sat((longint'(st_vy) * d) >>> 16, -DISP_MAX, DISP_MAX);
    sin_cos(st_hd, s, c);
    gx = ((bx * s - by * c) >>> 28) + longint'(st_x);
    gy = ((bx * c + by * s) >>> 28) + longint'(st_y);
    nx = 32'(sat(gx, -64'sd2147483648, 64'sd2147483647));
    ny = 32'(sat(gy, -64'sd2147483648, 64'sd2147483647));
    nh = st_hd + 32'(longint'(st_yaw) * d);
  endfunction

  function automatic pose_rsp_t integrate_pose(odo_req_t r);
    pose_rsp_t p;
    logic signed [31:0] nx, ny;
    logic [31:0] nh;
    p.status = 1'b0;
    case (r.req)
      poi_pkg::REQ_SET: begin
        st_x = r.px; st_y = r.py; st_hd = r.hd; st_time = r.stamp; st_init = 1'b1;
      end
      poi_pkg::REQ_FORCE: begin
        st_hd = r.hd; st_yaw = 0;
      end
      poi_pkg::REQ_UPDATE: begin
        if (r.stamp < st_time) p.status = 1'b1;
        else begin
          dead_reckon(r.stamp - st_time, nx, ny, nh);
          st_x = nx; st_y = ny; st_hd = nh;
          st_vx = r.vx; st_vy = r.vy; st_yaw = r.yaw; st_time = r.stamp;
        end
      end
      default: ;
    endcase
    p.x = st_x; p.y = st_y; p.hd = st_hd;
    if (r.req == poi_pkg::REQ_PREDICT) begin
      if (r.stamp < st_time) begin
        p.status = 1'b1; p.x = 0; p.y = 0; p.hd = 0;
      end else if (r.stamp != st_time) begin
        dead_reckon(r.stamp - st_time, nx, ny, nh);
        p.x = nx; p.y = ny; p.hd = nh;
      end
    end
    p.init = st_init;
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // Driver
  int in_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_poses.push_back(integrate_pose(pending_reqs.pop_front()));
        in_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      end
      if (!(in_valid && in_stall)) begin
        if (in_wait == 0 && pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_req_type <= pending_reqs[0].req;
          in_time_stamp <= pending_reqs[0].stamp;
          in_vel_x_in <= pending_reqs[0].vx;
          in_vel_y_in <= pending_reqs[0].vy;
          in_yaw_rate_in <= pending_reqs[0].yaw;
          in_pose_x_in <= pending_reqs[0].px;
          in_pose_y_in <= pending_reqs[0].py;
          in_heading_in <= pending_reqs[0].hd;
        end else begin
          in_valid <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // Monitor
  int out_wait = 0;
  always @(posedge clk) begin
    pose_rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = expected_poses.pop_front();
          if (out_status !== want.status)
            report("status", 32'(out_status), 32'(want.status));
          if (out_pos_x_out !== want.x) report("pos_x", out_pos_x_out, want.x);
          if (out_pos_y_out !== want.y) report("pos_y", out_pos_y_out, want.y);
          if (out_heading_out !== want.hd) report("heading", out_heading_out, want.hd);
          if (out_is_initialized !== want.init)
            report("is_initialized", 32'(out_is_initialized), 32'(want.init));
        end
        out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      end
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("planar_odometry_integrator_core: mismatch");
      $finish;
    end
  end

  function automatic odo_req_t rand_req(poi_pkg::req_t k, logic [31:0] stamp);
    odo_req_t r;
    r.req = k;
    r.stamp = stamp;
    r.vx = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed(12'($urandom)) <<< 8);
    r.vy = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed(12'($urandom)) <<< 8);
    r.yaw = 24'($urandom);
    r.px = $urandom_range(0, 5) == 0 ? 32'($urandom) : 32'($signed(20'($urandom)) <<< 8);
    r.py = $urandom_range(0, 5) == 0 ? 32'($urandom) : 32'($signed(20'($urandom)) <<< 8);
    r.hd = $urandom;
    return r;
  endfunction

  function automatic odo_req_t fixed_req(poi_pkg::req_t k, logic [31:0] stamp,
                                         logic signed [23:0] v,
                                         logic signed [31:0] p, logic [31:0] h);
    odo_req_t r;
    r.req = k; r.stamp = stamp; r.vx = v; r.vy = -v; r.yaw = v;
    r.px = p; r.py = ~p; r.hd = h;
    return r;
  endfunction

  initial begin
    logic [31:0] now;
    int kind;
    st_x = 0; st_y = 0; st_hd = 0; st_vx = 0; st_vy = 0; st_yaw = 0;
    st_time = 0; st_init = 0;
    // Directed: before init, extremes, backwards time, zero dt, force
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'd100, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'd200, 24'sh7FFFFF, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'hFFFFFFFF, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'hFFFFFFFF, 24'sh800000, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'd5, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'd5, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_SET, 32'd0, 0, 32'sh7FFFFFFF,
                                     32'h40000000));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'd0, 24'sh7FFFFF, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'd0, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'hFFFFFFFF, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_SET, 32'd1000, 0, 32'sh80000000,
                                     32'hC0000000));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'd1000, 24'sh800000, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'h80000000, 24'sh7FFFFF, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_FORCE, 32'd0, 0, 0, 32'h80000000));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'hFFFFFFFF, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'd999, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_PREDICT, 32'd999, 0, 0, 0));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_FORCE, 32'hFFFFFFFF, 24'sh7FFFFF, 0,
                                     32'hFFFFFFFF));
    pending_reqs.push_back(fixed_req(poi_pkg::REQ_UPDATE, 32'hFFFFFFFF, 0, 0, 0));
    // Random: mostly forward-moving time with occasional resets and jumps back
    now = 0;
    for (int n = 0; n < 1880; n++) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) now = $urandom;
      else now = now + $urandom_range(0, 3) * $urandom_range(0, 20000);
      if (kind < 8) pending_reqs.push_back(rand_req(poi_pkg::REQ_SET, now));
      else if (kind < 14) pending_reqs.push_back(rand_req(poi_pkg::REQ_FORCE, $urandom));
      else if (kind < 55) pending_reqs.push_back(rand_req(poi_pkg::REQ_UPDATE, now));
      else pending_reqs.push_back(rand_req(poi_pkg::REQ_PREDICT, now));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0);
    wait (expected_poses.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_poses.size() == 0)
      $display("planar_odometry_integrator_core: match");
    else
      $display("planar_odometry_integrator_core: mismatch");
    $finish;
  end
endmodule

@@ files.f @@
design/poi_pkg.sv
design/poi_cordic.sv
design/planar_odometry_integrator_core.sv
verif/planar_odometry_integrator_core_tb.sv
